FILE: rtl/bup_pkg.sv
// Shared types and constants for the BGRA un-premultiply pipeline.
package bup_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 3;
  // Width of channel * 255 (the dividend of each lane).
  localparam int unsigned NUM_W      = 2 * CH_W;
  // Restoring division steps done by one pipeline stage.
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;
  // Input register, division stages and output register.
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 2;

  localparam logic [CH_W-1:0] ALPHA_ZERO = '0;

  // Lane index for each colour channel, in input byte order.
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  ch_rem_t;
  typedef logic [NUM_CH-1:0][NUM_W-1:0] ch_work_t;

  // Data carried from stage to stage. The work word holds the dividend bits
  // not yet used in its high end and the quotient bits found in its low end.
  typedef struct packed {
    ch_rem_t             rem;
    ch_work_t            work;
    logic [PIXEL_W-1:0]  pixel;
  } div_data_t;

  function automatic logic [CH_W-1:0] alpha_of(input logic [PIXEL_W-1:0] px);
    return px[PIXEL_W-1 -: CH_W];
  endfunction

endpackage

FILE: rtl/bup_prep.sv
// Input register: splits the pixel and forms channel * 255 for each lane.
module bup_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bup_pkg::PIXEL_W-1:0] pixel_i,
  output logic                        valid_o,
  output bup_pkg::div_data_t          data_o
);
  import bup_pkg::*;

  logic      valid_q;
  div_data_t data_d;
  div_data_t data_q;

  always_comb begin
    data_d.pixel = pixel_i;
    data_d.rem   = '0;
    for (int unsigned c = 0; c < NUM_CH; c++) begin
      // c * 255 as (c << 8) - c.
      data_d.work[c] = {pixel_i[c*CH_W +: CH_W], {CH_W{1'b0}}}
                     - {{CH_W{1'b0}}, pixel_i[c*CH_W +: CH_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/bup_div_stage.sv
// One division stage: a few restoring steps on all three colour lanes.
module bup_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bup_pkg::div_data_t data_i,
  output logic               valid_o,
  output bup_pkg::div_data_t data_o
);
  import bup_pkg::*;

  logic      valid_q;
  div_data_t data_d;
  div_data_t data_q;

  always_comb begin
    logic [CH_W-1:0]  divisor;
    logic [CH_W:0]    trial;
    logic [CH_W-1:0]  rem;
    logic [NUM_W-1:0] work;
    divisor      = alpha_of(data_i.pixel);
    data_d       = data_i;
    for (int unsigned c = 0; c < NUM_CH; c++) begin
      rem  = data_i.rem[c];
      work = data_i.work[c];
      for (int unsigned s = 0; s < DIV_STEPS; s++) begin
        // Bring down the next dividend bit; for a nonzero divisor the remainder
        // stays below it, so it fits in one byte after the subtract.
        trial = {rem, work[NUM_W-1]};
        work  = {work[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial   = trial - {1'b0, divisor};
          work[0] = 1'b1;
        end
        rem = trial[CH_W-1:0];
      end
      data_d.rem[c]  = rem;
      data_d.work[c] = work;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/bup_pack.sv
// Output register: picks pass-through or the reordered, scaled pixel.
module bup_pack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  bup_pkg::div_data_t          data_i,
  output logic                        valid_o,
  output logic [bup_pkg::PIXEL_W-1:0] pixel_o
);
  import bup_pkg::*;

  logic               valid_q;
  logic [PIXEL_W-1:0] pixel_d;
  logic [PIXEL_W-1:0] pixel_q;
  logic [CH_W-1:0]    alpha;

  always_comb begin
    alpha = alpha_of(data_i.pixel);
    if (alpha == ALPHA_ZERO) begin
      // Fully transparent words leave unchanged, bytes not swapped.
      pixel_d = data_i.pixel;
    end else begin
      // Only the low byte of each quotient is kept.
      pixel_d = {alpha,
                 data_i.work[CH_BLUE][CH_W-1:0],
                 data_i.work[CH_GREEN][CH_W-1:0],
                 data_i.work[CH_RED][CH_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

FILE: rtl/bgra_unpremultiply_to_rgba_top.sv
// Top level of the BGRA premultiplied to RGBA straight-alpha converter.
//
//   Channel   Dir  Handshake                        Payload
//   s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata[31:0] = pixel_in
//   m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata[31:0] = pixel_out
//
// One request is taken and one result leaves every cycle while the output is
// not stalled. The path is an input register, four division stages and an
// output register. Each division stage runs four restoring steps per lane,
// and the sixteen quotient bits of the three colour lanes set the depth.
// Reset clears every stage's valid bit; the data registers are not reset.
// A stall at the output backs up only as far as empty stages allow: each
// stage loads whenever it is empty or the stage after it loads, so bubbles
// are squeezed out and no request is lost or repeated.
module bgra_unpremultiply_to_rgba_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] pixel_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] pixel_out
);
  import bup_pkg::*;

  // Stage 0 is the input register, stages 1 to DIV_STAGES divide, and the
  // last one is the output register.
  logic [PIPE_DEPTH-1:0] stage_en;
  logic [PIPE_DEPTH-1:0] stage_valid;
  div_data_t             stage_data [DIV_STAGES+1];

  // Ready travels backward: a stage may load when it is empty or when the
  // stage downstream takes its present contents in the same cycle.
  always_comb begin
    stage_en[PIPE_DEPTH-1] = !stage_valid[PIPE_DEPTH-1] || m_axis_tready_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign s_axis_tready_o = stage_en[0];

  bup_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stage_en[0]),
    .valid_i (s_axis_tvalid_i),
    .pixel_i (s_axis_tdata_i),
    .valid_o (stage_valid[0]),
    .data_o  (stage_data[0])
  );

  // Each division stage consumes four dividend bits of every lane.
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    bup_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (stage_en[g]),
      .valid_i (stage_valid[g-1]),
      .data_i  (stage_data[g-1]),
      .valid_o (stage_valid[g]),
      .data_o  (stage_data[g])
    );
  end

  bup_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stage_en[PIPE_DEPTH-1]),
    .valid_i (stage_valid[DIV_STAGES]),
    .data_i  (stage_data[DIV_STAGES]),
    .valid_o (stage_valid[PIPE_DEPTH-1]),
    .pixel_o (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = stage_valid[PIPE_DEPTH-1];

endmodule

FILE: rtl/bup_checker.sv
// Port-level checks for the un-premultiply pipeline, bound to its top level.
module bup_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);
  import bup_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] inflight_q;
  logic [CNT_W-1:0] inflight_d;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_fire && !out_fire) begin
      inflight_d = inflight_q + CNT_W'(1);
    end else if (out_fire && !in_fire) begin
      inflight_d = inflight_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or vanished");

  // Input is refused only when a result is waiting at the output.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input refused while output is empty");

  // No more requests in flight than pipeline stages.
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than stages");

  // A result is never shown without an accepted request behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> inflight_q != '0)
    else $error("result without a pending request");

endmodule

bind bgra_unpremultiply_to_rgba_top bup_checker u_bup_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: tb/unpremultiply_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every straight-alpha pixel of the converter.
module unpremultiply_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic                        s_ready_i,
  input  logic [bup_pkg::PIXEL_W-1:0] s_data_i,
  input  logic                        m_valid_i,
  input  logic                        m_ready_i,
  input  logic [bup_pkg::PIXEL_W-1:0] m_data_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 outstanding_o,
  output int unsigned                 checked_count_o
);
  import bup_pkg::*;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = '1;

  logic [PIXEL_W-1:0] expected_rgba_q[$];

  // Scale one premultiplied channel back up; quotients above 255 wrap.
  function automatic logic [CH_W-1:0] unscale_channel(input logic [CH_W-1:0] c,
                                                      input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] scaled;
    scaled = 16'(c) * 16'(ALPHA_OPAQUE);
    return CH_W'(scaled / 16'(a));
  endfunction

  function automatic logic [PIXEL_W-1:0] straight_alpha_pixel(input logic [PIXEL_W-1:0] px);
    logic [CH_W-1:0] blue, green, red, alpha;
    blue  = px[7:0];
    green = px[15:8];
    red   = px[23:16];
    alpha = px[31:24];
    if (alpha == ALPHA_ZERO) begin
      return px;
    end
    if (alpha != ALPHA_OPAQUE) begin
      blue  = unscale_channel(blue, alpha);
      green = unscale_channel(green, alpha);
      red   = unscale_channel(red, alpha);
    end
    return {alpha, blue, green, red};
  endfunction

  assign outstanding_o = expected_rgba_q.size();

  // The result side is handled before the request side, so a result can never
  // be matched against a request taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid_i && m_ready_i) begin
        if (expected_rgba_q.size() == 0) begin
          $error("pixel_out: unexpected result %08h with nothing pending", m_data_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          if (m_data_i !== expected_rgba_q[0]) begin
            $error("pixel_out mismatch: expected %08h, actual %08h",
                   expected_rgba_q[0], m_data_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
          void'(expected_rgba_q.pop_front());
          checked_count_o <= checked_count_o + 1;
        end
      end
      if (s_valid_i && s_ready_i) begin
        expected_rgba_q.push_back(straight_alpha_pixel(s_data_i));
      end
    end else begin
      mismatch_count_o <= 0;
      checked_count_o  <= 0;
    end
  end

endmodule

FILE: tb/bgra_unpremultiply_to_rgba_top_tb.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, pixel stimulus, back pressure and verdict.
module bgra_unpremultiply_to_rgba_top_tb;
  import bup_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 227;
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned NUM_DIRECTED     = 19;

  // Hand-picked pixels: transparent words that must pass through untouched,
  // opaque words that are only reordered, the smallest alpha where every
  // channel above it wraps, alpha one below opaque, and a few mid values.
  localparam logic [PIXEL_W-1:0] DIRECTED_PIXELS [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h00FF_FFFF, 32'h0012_3456,
    32'hFF00_0000, 32'hFFFF_FFFF, 32'hFF12_3456,
    32'h0101_0101, 32'h01FF_FFFF, 32'h0100_0000,
    32'hFEFE_FEFE, 32'hFE00_0000, 32'hFEFF_FFFF,
    32'h8080_8080, 32'h8040_8020, 32'h7F7F_7F7F,
    32'h0201_0203, 32'h40FF_0080, 32'hAA55_5555,
    32'h55AA_AAAA
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [PIXEL_W-1:0] s_axis_tdata_i = '0;   // [31:0] pixel_in
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [PIXEL_W-1:0] m_axis_tdata_o;        // [31:0] pixel_out

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked_count;

  // Percentages of cycles in which each side holds back.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles = 0;

  bgra_unpremultiply_to_rgba_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  unpremultiply_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid_i),
    .s_ready_i        (s_axis_tready_o),
    .s_data_i         (s_axis_tdata_i),
    .m_valid_i        (m_axis_tvalid_o),
    .m_ready_i        (m_axis_tready_i),
    .m_data_i         (m_axis_tdata_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .checked_count_o  (checked_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The receiver drops tready at random in the share of cycles set for the
  // current phase; with a share of zero it simply accepts every cycle.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Cycles in which neither side completes a handshake are counted; a long
  // run of them means the pipeline has hung or lost a result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mostly well-formed premultiplied pixels (every channel at most alpha),
  // with transparent, opaque and fully random words mixed in so that wrapping
  // channels and every data bit are exercised as well.
  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [CH_W-1:0] alpha;
    int unsigned     kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      return {ALPHA_ZERO, 24'($urandom)};
    end else if (kind == 1) begin
      return {8'hFF, 24'($urandom)};
    end else if (kind >= 8) begin
      return $urandom;
    end
    alpha = 8'($urandom_range(254, 1));
    return {alpha, 8'($urandom_range(alpha)), 8'($urandom_range(alpha)),
            8'($urandom_range(alpha))};
  endfunction

  // Offers one request and returns at the edge where it is accepted. The
  // ready flag is read right after the edge, before the block updates it,
  // so it is the value the block saw at that edge.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    requests_sent++;
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: a light sender against a receiver that stalls often. The
    // directed pixels go first under the same pressure.
    tx_idle_pct = 12;
    rx_idle_pct = 59;
    foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);
    run_random_phase(12, 59);
    // Phase two swaps the roles, phase three runs at full rate both ways.
    run_random_phase(59, 12);
    run_random_phase(0, 0);
    s_axis_tvalid_i <= 1'b0;

    // Drain the pipeline, then give it a few more cycles so that any stray
    // extra result would still be caught. The watchdog covers a hang here.
    while (outstanding != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);

    $display("Sent %0d pixels (%0d hand-picked, rest random) under three back-pressure mixes.",
             requests_sent, NUM_DIRECTED);
    $display("Checked %0d converted pixels; %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bup_pkg.sv
rtl/bup_prep.sv
rtl/bup_div_stage.sv
rtl/bup_pack.sv
rtl/bgra_unpremultiply_to_rgba_top.sv
rtl/bup_checker.sv
tb/unpremultiply_checker.sv
tb/bgra_unpremultiply_to_rgba_top_tb.sv
